// File: design/mpsrb_pkg.sv
// Shared types and constants for the multi-port serial ring buffer block.
// No dependencies; imported by the top level, the port checker and the testbench.
`default_nettype none

package mpsrb_pkg;

  localparam int unsigned REQ_W      = 3;
  localparam int unsigned PORT_W     = 2;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned RX_COUNT_W = 8;
  localparam int unsigned TX_USED_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_RX     = 3'd0,
    REQ_READ   = 3'd1,
    REQ_WRITE  = 3'd2,
    REQ_TXRDY  = 3'd3,
    REQ_STATUS = 3'd4
  } req_type_e;

endpackage

`default_nettype wire

// File: design/multi_port_serial_ring_buffers.sv
// Result word in the cycle after acceptance; one word per cycle when in_stall_o is low.
// Ring pointers and stores update at the accepting edge, so back-to-back words see each
// other's effects; data comes from the memory read-data registers, status from result regs.
// Reset: pointers and flags clear at once; the receive store is then zeroed one entry per
// cycle, all NUM_PORTS*RX_DEPTH entries (1024 by default), with in_stall_o held high.
// Depends on mpsrb_pkg and mpsrb_ram.
`default_nettype none

module multi_port_serial_ring_buffers #(
  parameter int unsigned NUM_PORTS = 4,
  parameter int unsigned RX_DEPTH  = 256,
  parameter int unsigned TX_DEPTH  = 128
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [mpsrb_pkg::REQ_W-1:0]       req_type_i,
  input  wire logic [mpsrb_pkg::PORT_W-1:0]      port_i,
  input  wire logic [mpsrb_pkg::DATA_W-1:0]      data_in_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [mpsrb_pkg::DATA_W-1:0]      data_out_o,
  output logic                                   data_valid_o,
  output logic      [mpsrb_pkg::RX_COUNT_W-1:0]  rx_count_o,
  output logic      [mpsrb_pkg::TX_USED_W-1:0]   tx_used_o,
  output logic                                   tx_empty_o,
  output logic                                   tx_active_o
);

  import mpsrb_pkg::*;

  localparam int unsigned PW      = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int unsigned RX_AW   = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW   = $clog2(TX_DEPTH);
  localparam int unsigned RX_MD   = NUM_PORTS * RX_DEPTH;
  localparam int unsigned TX_MD   = NUM_PORTS * TX_DEPTH;
  localparam int unsigned RX_MAW  = $clog2(RX_MD);
  localparam int unsigned TX_MAW  = $clog2(TX_MD);

  function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
    logic [RX_AW:0] n;
    n = {1'b0, p} + (RX_AW+1)'(1);
    return (n >= (RX_AW+1)'(RX_DEPTH)) ? '0 : n[RX_AW-1:0];
  endfunction

  function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
    logic [TX_AW:0] n;
    n = {1'b0, p} + (TX_AW+1)'(1);
    return (n >= (TX_AW+1)'(TX_DEPTH)) ? '0 : n[TX_AW-1:0];
  endfunction

  // per-port ring state
  logic [RX_AW-1:0] rx_head_q [NUM_PORTS];
  logic [RX_AW-1:0] rx_tail_q [NUM_PORTS];
  logic [TX_AW-1:0] tx_head_q [NUM_PORTS];
  logic [TX_AW-1:0] tx_tail_q [NUM_PORTS];
  logic             tx_en_q   [NUM_PORTS];

  logic              clr_busy_q;
  logic [RX_MAW-1:0] clr_addr_q;

  logic out_valid_q, data_valid_q, sel_tx_q;
  logic [RX_COUNT_W-1:0] rx_count_q;
  logic [TX_USED_W-1:0]  tx_used_q;
  logic tx_empty_q, tx_active_q;

  logic accept, upd;
  logic [PW+PORT_W-1:0] port_ext;
  logic [PW-1:0]        idx;
  logic                 port_ok;

  logic [RX_AW-1:0] rxh, rxt, rxh_d, rxt_d;
  logic [TX_AW-1:0] txh, txt, txh_d, txt_d;
  logic             ten, ten_d;
  logic rx_we, rx_re, tx_we, tx_re, dvalid, sel_tx;

  logic [RX_AW:0]               rx_cnt;
  logic [TX_AW:0]               tx_cnt;
  logic [RX_AW+RX_COUNT_W:0]    rx_cnt_ext;
  logic [TX_AW+TX_USED_W:0]     tx_cnt_ext;

  logic [RX_MAW-1:0] rx_base, rx_waddr, rx_raddr;
  logic [TX_MAW-1:0] tx_base, tx_waddr, tx_raddr;
  logic [DATA_W-1:0] rx_wdata, rx_rdata, tx_rdata;
  logic              rx_we_mem;

  assign in_stall_o = clr_busy_q | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  assign port_ext = (PW+PORT_W)'(port_i);
  assign idx      = port_ext[PW-1:0];
  assign port_ok  = port_ext < (PW+PORT_W)'(NUM_PORTS);
  assign upd      = accept & port_ok;

  assign rxh = rx_head_q[idx];
  assign rxt = rx_tail_q[idx];
  assign txh = tx_head_q[idx];
  assign txt = tx_tail_q[idx];
  assign ten = tx_en_q[idx];

  always_comb begin
    rxh_d  = rxh;
    rxt_d  = rxt;
    txh_d  = txh;
    txt_d  = txt;
    ten_d  = ten;
    rx_we  = 1'b0;
    rx_re  = 1'b0;
    tx_we  = 1'b0;
    tx_re  = 1'b0;
    dvalid = 1'b0;
    sel_tx = 1'b0;
    case (req_type_i)
      REQ_RX: begin
        rx_we = 1'b1;
        rxh_d = rx_next(rxh);
      end
      REQ_READ: begin
        // empty ring: stale byte at the tail, tail stays
        rx_re  = 1'b1;
        dvalid = 1'b1;
        if (rxh != rxt) begin
          rxt_d = rx_next(rxt);
        end
      end
      REQ_WRITE: begin
        tx_we = 1'b1;
        txh_d = tx_next(txh);
        ten_d = 1'b1;
      end
      REQ_TXRDY: begin
        if (ten) begin
          if (txh != txt) begin
            tx_re  = 1'b1;
            dvalid = 1'b1;
            sel_tx = 1'b1;
            txt_d  = tx_next(txt);
          end
          if (txt_d == txh) begin
            ten_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // occupancy after this word
  always_comb begin
    if (rxh_d >= rxt_d) begin
      rx_cnt = {1'b0, rxh_d} - {1'b0, rxt_d};
    end else begin
      rx_cnt = {1'b0, rxh_d} + (RX_AW+1)'(RX_DEPTH) - {1'b0, rxt_d};
    end
    if (txh_d >= txt_d) begin
      tx_cnt = {1'b0, txh_d} - {1'b0, txt_d};
    end else begin
      tx_cnt = {1'b0, txh_d} + (TX_AW+1)'(TX_DEPTH) - {1'b0, txt_d};
    end
  end

  assign rx_cnt_ext = (RX_AW+RX_COUNT_W+1)'(rx_cnt);
  assign tx_cnt_ext = (TX_AW+TX_USED_W+1)'(tx_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        rx_head_q[i] <= '0;
        rx_tail_q[i] <= '0;
        tx_head_q[i] <= '0;
        tx_tail_q[i] <= '0;
        tx_en_q[i]   <= 1'b0;
      end
    end else if (upd) begin
      rx_head_q[idx] <= rxh_d;
      rx_tail_q[idx] <= rxt_d;
      tx_head_q[idx] <= txh_d;
      tx_tail_q[idx] <= txt_d;
      tx_en_q[idx]   <= ten_d;
    end
  end

  // receive store clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      if (clr_addr_q == RX_MAW'(RX_MD - 1)) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + RX_MAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_valid_q <= port_ok & dvalid;
      sel_tx_q     <= sel_tx;
      rx_count_q   <= port_ok ? rx_cnt_ext[RX_COUNT_W-1:0] : '0;
      tx_used_q    <= port_ok ? tx_cnt_ext[TX_USED_W-1:0] : '0;
      tx_empty_q   <= port_ok & (txh_d == txt_d);
      tx_active_q  <= port_ok & ten_d;
    end
  end

  assign rx_base  = RX_MAW'(RX_MAW'(idx) * RX_MAW'(RX_DEPTH));
  assign tx_base  = TX_MAW'(TX_MAW'(idx) * TX_MAW'(TX_DEPTH));
  assign rx_raddr = rx_base + RX_MAW'(rxt);
  assign tx_waddr = tx_base + TX_MAW'(txh_d);
  assign tx_raddr = tx_base + TX_MAW'(txt_d);

  assign rx_we_mem = clr_busy_q | (upd & rx_we);
  assign rx_waddr  = clr_busy_q ? clr_addr_q : (rx_base + RX_MAW'(rxh));
  assign rx_wdata  = clr_busy_q ? '0 : data_in_i;

  mpsrb_ram #(
    .DEPTH  (RX_MD),
    .WIDTH  (DATA_W),
    .ADDR_W (RX_MAW)
  ) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we_mem),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .re_i    (upd & rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  mpsrb_ram #(
    .DEPTH  (TX_MD),
    .WIDTH  (DATA_W),
    .ADDR_W (TX_MAW)
  ) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (upd & tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (data_in_i),
    .re_i    (upd & tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign data_valid_o = data_valid_q;
  assign data_out_o   = !data_valid_q ? '0 : (sel_tx_q ? tx_rdata : rx_rdata);
  assign rx_count_o   = rx_count_q;
  assign tx_used_o    = tx_used_q;
  assign tx_empty_o   = tx_empty_q;
  assign tx_active_o  = tx_active_q;

endmodule

`default_nettype wire

// File: design/mpsrb_ram.sv
// Simple dual-port byte store: one write port, one read port with registered data.
// No package dependency; instantiated by the top level for the receive and transmit rings.
`default_nettype none

module mpsrb_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/mpsrb_checker.sv
// Port-level checks for multi_port_serial_ring_buffers, with the bind that attaches them.
// Depends on mpsrb_pkg for field widths.
`default_nettype none

module mpsrb_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic [mpsrb_pkg::DATA_W-1:0]     data_out_o,
  input wire logic                             data_valid_o,
  input wire logic [mpsrb_pkg::RX_COUNT_W-1:0] rx_count_o
);

  import mpsrb_pkg::*;

  logic in_acc, out_acc;

  assign in_acc  = in_valid_i & ~in_stall_o;
  assign out_acc = out_valid_o & ~out_stall_i;

  // every accepted word shows its result on the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted word produced no result next cycle");

  // no result appears without a word behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_acc) && !in_acc |=> !out_valid_o)
    else $error("result word without an accepted input word");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_out_o)
      && $stable(data_valid_o) && $stable(rx_count_o))
    else $error("stalled result changed");

  // data byte is zero unless flagged
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !data_valid_o |-> data_out_o == '0)
    else $error("data_out nonzero without data_valid");

endmodule

bind multi_port_serial_ring_buffers mpsrb_checker u_mpsrb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .data_out_o   (data_out_o),
  .data_valid_o (data_valid_o),
  .rx_count_o   (rx_count_o)
);

`default_nettype wire

// File: tb/sv/tb_multi_port_serial_ring_buffers.sv
// Self-checking testbench for multi_port_serial_ring_buffers: queued words go in through a
// clocked driver, a clocked monitor checks each result word against an in-bench ring model.
// Depends on mpsrb_pkg and the block's RTL.
`default_nettype none

module tb_multi_port_serial_ring_buffers;
  import mpsrb_pkg::*;

  localparam int unsigned PORTS   = 4;
  localparam int unsigned RX_SLOTS = 256;
  localparam int unsigned TX_SLOTS = 128;
  // codes past the status query, which the block treats as status
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [PORT_W-1:0] port;
    logic [DATA_W-1:0] data;
  } word_t;

  typedef struct packed {
    logic [DATA_W-1:0]     data_out;
    logic                  data_valid;
    logic [RX_COUNT_W-1:0] rx_count;
    logic [TX_USED_W-1:0]  tx_used;
    logic                  tx_empty;
    logic                  tx_active;
  } result_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [REQ_W-1:0]      req_type_i  = '0;
  logic [PORT_W-1:0]     port_i      = '0;
  logic [DATA_W-1:0]     data_in_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [DATA_W-1:0]     data_out_o;
  logic                  data_valid_o;
  logic [RX_COUNT_W-1:0] rx_count_o;
  logic [TX_USED_W-1:0]  tx_used_o;
  logic                  tx_empty_o;
  logic                  tx_active_o;

  multi_port_serial_ring_buffers dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .port_i      (port_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_out_o  (data_out_o),
    .data_valid_o(data_valid_o),
    .rx_count_o  (rx_count_o),
    .tx_used_o   (tx_used_o),
    .tx_empty_o  (tx_empty_o),
    .tx_active_o (tx_active_o)
  );

  // ring model state
  logic [DATA_W-1:0]     rx_mem [PORTS][RX_SLOTS];
  logic [DATA_W-1:0]     tx_mem [PORTS][TX_SLOTS];
  logic [RX_COUNT_W-1:0] rx_hd [PORTS];
  logic [RX_COUNT_W-1:0] rx_tl [PORTS];
  logic [TX_USED_W-1:0]  tx_hd [PORTS];
  logic [TX_USED_W-1:0]  tx_tl [PORTS];
  logic                  tx_on [PORTS];

  word_t   words_to_send[$];
  result_t results_due[$];
  int      fail_count    = 0;
  int      send_idle_pct = 0;
  int      stall_pct     = 0;
  logic    pressure_go   = 1'b0;
  logic    hold_on       = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("FAIL multi_port_serial_ring_buffers");
    $finish;
  end

  function automatic result_t step_rings(input logic [REQ_W-1:0] req,
                                         input logic [PORT_W-1:0] p,
                                         input logic [DATA_W-1:0] d);
    result_t          r;
    logic [TX_USED_W-1:0] t;
    r = '0;
    case (req)
      REQ_RX: begin
        rx_mem[p][rx_hd[p]] = d;
        rx_hd[p] = rx_hd[p] + 1'b1;
      end
      REQ_READ: begin
        // empty ring still answers with the stale slot at the tail
        r.data_out   = rx_mem[p][rx_tl[p]];
        r.data_valid = 1'b1;
        if (rx_hd[p] != rx_tl[p]) rx_tl[p] = rx_tl[p] + 1'b1;
      end
      REQ_WRITE: begin
        t = tx_hd[p] + 1'b1;
        tx_mem[p][t] = d;
        tx_hd[p] = t;
        tx_on[p] = 1'b1;
      end
      REQ_TXRDY: begin
        if (tx_on[p]) begin
          t = tx_tl[p];
          if (tx_hd[p] != t) begin
            t = t + 1'b1;
            r.data_out   = tx_mem[p][t];
            r.data_valid = 1'b1;
            tx_tl[p] = t;
          end
          if (t == tx_hd[p]) tx_on[p] = 1'b0;
        end
      end
      default: ;
    endcase
    r.rx_count  = rx_hd[p] - rx_tl[p];
    r.tx_used   = tx_hd[p] - tx_tl[p];
    r.tx_empty  = (tx_hd[p] == tx_tl[p]);
    r.tx_active = tx_on[p];
    return r;
  endfunction

  task automatic queue_word(input logic [REQ_W-1:0] rq, input int pt, input int dt);
    word_t w;
    w.req  = rq;
    w.port = pt[PORT_W-1:0];
    w.data = dt[DATA_W-1:0];
    words_to_send.push_back(w);
  endtask

  // mostly short bursts that write into a ring and then drain it, with loose words mixed in
  task automatic queue_traffic(input int n);
    int added;
    int pt;
    int k;
    int j;
    added = 0;
    while (added < n) begin
      pt = $urandom_range(PORTS - 1);
      k  = $urandom_range(8, 1);
      case ($urandom_range(3))
        0: begin
          for (j = 0; j < k; j++) queue_word(REQ_RX, pt, $urandom_range(255));
          for (j = 0; j < k + $urandom_range(1); j++) queue_word(REQ_READ, pt, $urandom_range(255));
          added += 2 * k;
        end
        1: begin
          for (j = 0; j < k; j++) queue_word(REQ_WRITE, pt, $urandom_range(255));
          for (j = 0; j < k + $urandom_range(2); j++)
            queue_word(REQ_TXRDY, pt, $urandom_range(255));
          added += 2 * k;
        end
        default: begin
          queue_word(REQ_W'($urandom_range(REQ_SPARE_LAST, 0)), pt, $urandom_range(255));
          added += 1;
        end
      endcase
    end
  endtask

  task automatic drain_queue();
    while (words_to_send.size() > 0 || in_valid_i) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    word_t w;
    result_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        r = step_rings(req_type_i, port_i, data_in_i);
        results_due.push_back(r);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (words_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          w = words_to_send.pop_front();
          req_type_i <= w.req;
          port_i     <= w.port;
          data_in_i  <= w.data;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    result_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          e = results_due.pop_front();
          check_field("data_out", e.data_out, data_out_o);
          check_field("data_valid", e.data_valid, data_valid_o);
          check_field("rx_count", e.rx_count, rx_count_o);
          check_field("tx_used", e.tx_used, tx_used_o);
          check_field("tx_empty", e.tx_empty, tx_empty_o);
          check_field("tx_active", e.tx_active, tx_active_o);
        end
      end
      out_stall_i <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin : hold_off
    int n;
    wait (pressure_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    for (n = 0; n < 240; n++) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  initial begin : main_seq
    int p;
    int s;
    int k;
    for (p = 0; p < PORTS; p++) begin
      for (s = 0; s < RX_SLOTS; s++) rx_mem[p][s] = '0;
      for (s = 0; s < TX_SLOTS; s++) tx_mem[p][s] = '0;
      rx_hd[p] = '0;
      rx_tl[p] = '0;
      tx_hd[p] = '0;
      tx_tl[p] = '0;
      tx_on[p] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty reads, inactive transmitter, byte extremes, drain and flag clear
    queue_word(REQ_STATUS, 0, 8'h00);
    queue_word(REQ_READ,   0, 8'hFF);
    queue_word(REQ_TXRDY,  0, 8'h00);
    queue_word(REQ_RX,     0, 8'hFF);
    queue_word(REQ_RX,     0, 8'h00);
    queue_word(REQ_READ,   0, 8'h00);
    queue_word(REQ_READ,   0, 8'h00);
    queue_word(REQ_READ,   0, 8'h00);
    queue_word(REQ_WRITE,  1, 8'hFF);
    queue_word(REQ_WRITE,  1, 8'h00);
    queue_word(REQ_STATUS, 1, 8'hFF);
    queue_word(REQ_TXRDY,  1, 8'h00);
    queue_word(REQ_TXRDY,  1, 8'h00);
    queue_word(REQ_TXRDY,  1, 8'h00);
    queue_word(REQ_SPARE_FIRST,         3, 8'hAA);
    queue_word(REQ_SPARE_FIRST + 3'd1,  3, 8'h55);
    queue_word(REQ_SPARE_LAST,          3, 8'hFF);
    queue_word(REQ_RX,     3, 8'hA5);
    queue_word(REQ_READ,   3, 8'h00);
    queue_word(REQ_WRITE,  2, 8'h5A);
    queue_word(REQ_TXRDY,  2, 8'h00);
    queue_word(REQ_TXRDY,  2, 8'h00);
    drain_queue();

    queue_traffic(110);
    drain_queue();

    send_idle_pct <= 78;
    queue_traffic(110);
    drain_queue();

    send_idle_pct <= 0;
    stall_pct     <= 78;
    queue_traffic(110);
    drain_queue();

    // both sides idle lightly; both rings overflow and wrap
    send_idle_pct <= 6;
    stall_pct     <= 6;
    for (k = 0; k < RX_SLOTS + 2; k++) queue_word(REQ_RX, 3, $urandom_range(255));
    for (k = 0; k < 4; k++) queue_word(REQ_READ, 3, $urandom_range(255));
    for (k = 0; k < TX_SLOTS + 2; k++) queue_word(REQ_WRITE, 2, $urandom_range(255));
    for (k = 0; k < 6; k++) queue_word(REQ_TXRDY, 2, $urandom_range(255));
    queue_traffic(20);
    drain_queue();

    send_idle_pct <= 0;
    stall_pct     <= 0;
    pressure_go   <= 1'b1;
    queue_traffic(60);
    drain_queue();

    for (k = 0; k < 4000 && results_due.size() > 0; k++) @(posedge clk_i);
    if (results_due.size() > 0) begin
      $error("%0d result words never arrived", results_due.size());
      fail_count++;
    end
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS multi_port_serial_ring_buffers");
    end else begin
      $display("FAIL multi_port_serial_ring_buffers");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
design/mpsrb_pkg.sv
design/mpsrb_ram.sv
design/multi_port_serial_ring_buffers.sv
design/mpsrb_checker.sv
tb/sv/tb_multi_port_serial_ring_buffers.sv
